/* rtl/core/tmam_pkg.sv */
// Shared types, codes and default sizes for the touch median affine mapper.
// Depends on nothing; every file of the mapper imports it.
package tmam_pkg;

   // Default sizes handed to the top level parameters.
   localparam int TMAM_SCREEN_WIDTH   = 320;
   localparam int TMAM_SCREEN_HEIGHT  = 240;
   localparam int TMAM_SAMPLE_BITS    = 12;
   localparam int TMAM_COEF_FRAC_BITS = 16;

   // Coefficient word and configuration index width.
   localparam int COEF_W  = 32;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_AX   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CX   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_AY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CY   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_VALID = 3'd6;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NOT_PRESSED = 2'd1,
      STATUS_NOT_CAL     = 2'd2
   } status_type;

   // Coefficients of one screen axis: gain on raw x, gain on raw y, offset.
   typedef struct packed {
      logic signed [COEF_W-1:0] ca;
      logic signed [COEF_W-1:0] cb;
      logic signed [COEF_W-1:0] cc;
   } coef_set_type;

endpackage

/* rtl/core/tmam_median5.sv */
// Three-stage pipelined median of five unsigned samples.
// Depends on tmam_pkg for the default sample width.
module tmam_median5 import tmam_pkg::*; #(
   parameter int W = TMAM_SAMPLE_BITS
) (
   input  logic                clock,
   input  logic [4:0][W-1:0]   samp,
   output logic [W-1:0]        med
);

   // Stage 1: sort two pairs, carry the fifth sample.
   logic [W-1:0] a1_in, b1_in, c1_in, d1_in;
   logic [W-1:0] a1_ff, b1_ff, c1_ff, d1_ff, e1_ff;

   always_comb begin
      a1_in = (samp[1] < samp[0]) ? samp[1] : samp[0];
      b1_in = (samp[1] < samp[0]) ? samp[0] : samp[1];
      c1_in = (samp[3] < samp[2]) ? samp[3] : samp[2];
      d1_in = (samp[3] < samp[2]) ? samp[2] : samp[3];
   end

   always_ff @(posedge clock) begin
      a1_ff <= a1_in;
      b1_ff <= b1_in;
      c1_ff <= c1_in;
      d1_ff <= d1_in;
      e1_ff <= samp[4];
   end

   // Stage 2: the smaller pair minimum lies below three others, so drop it.
   // The median is then the second smallest of the four left; sort the
   // loose pair so the last stage needs only two compares.
   logic [W-1:0] p2_in, q2_in, r_raw, r2_in, e2_in;
   logic [W-1:0] p2_ff, q2_ff, r2_ff, e2_ff;

   always_comb begin
      if (a1_ff <= c1_ff) begin
         p2_in = c1_ff;
         q2_in = d1_ff;
         r_raw = b1_ff;
      end else begin
         p2_in = a1_ff;
         q2_in = b1_ff;
         r_raw = d1_ff;
      end
      r2_in = (e1_ff < r_raw) ? e1_ff : r_raw;
      e2_in = (e1_ff < r_raw) ? r_raw : e1_ff;
   end

   always_ff @(posedge clock) begin
      p2_ff <= p2_in;
      q2_ff <= q2_in;
      r2_ff <= r2_in;
      e2_ff <= e2_in;
   end

   // Stage 3: drop the smallest of the four; the median is the minimum
   // of the three that remain.
   logic [W-1:0] med_in, med_ff;

   always_comb begin
      if (p2_ff <= r2_ff) begin
         med_in = (r2_ff < q2_ff) ? r2_ff : q2_ff;
      end else begin
         med_in = (e2_ff < p2_ff) ? e2_ff : p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      med_ff <= med_in;
   end

   assign med = med_ff;

endmodule

/* rtl/core/tmam_affine_axis.sv */
// Three-stage affine map of one screen axis: multiply, sum, round and clamp.
// Depends on tmam_pkg for the coefficient set type and word width.
module tmam_affine_axis import tmam_pkg::*; #(
   parameter int SAMPLE_BITS = TMAM_SAMPLE_BITS,
   parameter int FRAC_BITS   = TMAM_COEF_FRAC_BITS,
   parameter int SIZE        = TMAM_SCREEN_WIDTH,
   parameter int OUT_W       = $clog2(SIZE)
) (
   input  logic                   clock,
   input  coef_set_type           coef,
   input  logic [SAMPLE_BITS-1:0] rx,
   input  logic [SAMPLE_BITS-1:0] ry,
   output logic [OUT_W-1:0]       pos
);

   localparam int PW = COEF_W + SAMPLE_BITS + 1;
   localparam int AW = PW + 2;
   localparam logic [AW-1:0] HALF     = AW'(1) << (FRAC_BITS - 1);
   localparam logic [AW-1:0] SIZE_A   = AW'(SIZE);
   localparam logic [OUT_W-1:0] LAST  = OUT_W'(SIZE - 1);

   // Stage 1: the two gain products; samples enter as non-negative values.
   logic signed [SAMPLE_BITS:0] rx_s, ry_s;
   logic signed [PW-1:0] prod_a_in, prod_b_in, prod_a_ff, prod_b_ff;

   assign rx_s = signed'({1'b0, rx});
   assign ry_s = signed'({1'b0, ry});

   always_comb begin
      prod_a_in = coef.ca * rx_s;
      prod_b_in = coef.cb * ry_s;
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

   // Stage 2: exact sum with the offset; the user must hold the coefficients
   // still while transactions are in flight; the block does not enforce it.
   logic signed [AW-1:0] acc_in, acc_ff;

   assign acc_in = AW'(prod_a_ff) + AW'(prod_b_ff) + AW'(coef.cc);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Stage 3: negative values clamp to zero; others round half up, which
   // is half away from zero here, and saturate at the last pixel.
   logic [AW-1:0] rnd, mag;
   logic [OUT_W-1:0] pos_in, pos_ff;

   always_comb begin
      rnd = unsigned'(acc_ff) + HALF;
      mag = rnd >> FRAC_BITS;
      if (acc_ff[AW-1]) begin
         pos_in = '0;
      end else if (mag >= SIZE_A) begin
         pos_in = LAST;
      end else begin
         pos_in = mag[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   assign pos = pos_ff;

endmodule

/* rtl/core/touch_median_affine_mapper.sv */
// Top level of the touch median affine mapper: configuration registers,
// status pipeline and the median and affine units. Depends on tmam_pkg,
// tmam_median5 and tmam_affine_axis.
//
//   channel   ports                          handshake
//   --------  -----------------------------  ------------------------------
//   request   req_pen_down, req_xs*, req_ys* start high while busy is low
//   response  rsp_status, rsp_median_*,      rsp_valid strobe, one cycle
//             rsp_col, rsp_row
//   config    csr_index, csr_wdata           csr_wr_en, taken at once
//
// A transaction may start in every cycle; its response passes through the
// three median compare stages and the multiply, sum and round/clamp
// stages of the affine unit. busy is high only during reset.
// Synchronous reset clears the valid pipeline and the configuration
// registers. The receiver cannot stall, so the pipeline always advances.
module touch_median_affine_mapper import tmam_pkg::*; #(
   parameter int SCREEN_WIDTH   = TMAM_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT  = TMAM_SCREEN_HEIGHT,
   parameter int SAMPLE_BITS    = TMAM_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = TMAM_COEF_FRAC_BITS,
   parameter int SX_W           = $clog2(SCREEN_WIDTH),
   parameter int SY_W           = $clog2(SCREEN_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_pen_down,
   input  logic [SAMPLE_BITS-1:0] req_xs0,
   input  logic [SAMPLE_BITS-1:0] req_xs1,
   input  logic [SAMPLE_BITS-1:0] req_xs2,
   input  logic [SAMPLE_BITS-1:0] req_xs3,
   input  logic [SAMPLE_BITS-1:0] req_xs4,
   input  logic [SAMPLE_BITS-1:0] req_ys0,
   input  logic [SAMPLE_BITS-1:0] req_ys1,
   input  logic [SAMPLE_BITS-1:0] req_ys2,
   input  logic [SAMPLE_BITS-1:0] req_ys3,
   input  logic [SAMPLE_BITS-1:0] req_ys4,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COEF_W-1:0]      csr_wdata,
   output logic                   rsp_valid,
   output status_type             rsp_status,
   output logic [SAMPLE_BITS-1:0] rsp_median_x,
   output logic [SAMPLE_BITS-1:0] rsp_median_y,
   output logic [SX_W-1:0]        rsp_col,
   output logic [SY_W-1:0]        rsp_row
);

   localparam int MED_LAT = 3;
   localparam int LAT     = 6;

   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration registers.
   coef_set_type coef_x_ff, coef_y_ff;
   logic         cal_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
         cal_valid_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_AX:   coef_x_ff.ca <= signed'(csr_wdata);
            CSR_COEF_BX:   coef_x_ff.cb <= signed'(csr_wdata);
            CSR_COEF_CX:   coef_x_ff.cc <= signed'(csr_wdata);
            CSR_COEF_AY:   coef_y_ff.ca <= signed'(csr_wdata);
            CSR_COEF_BY:   coef_y_ff.cb <= signed'(csr_wdata);
            CSR_COEF_CY:   coef_y_ff.cc <= signed'(csr_wdata);
            CSR_CAL_VALID: cal_valid_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Status is settled at entry; the not-calibrated check wins.
   status_type st_in;

   always_comb begin
      if (!cal_valid_ff) begin
         st_in = STATUS_NOT_CAL;
      end else if (!req_pen_down) begin
         st_in = STATUS_NOT_PRESSED;
      end else begin
         st_in = STATUS_OK;
      end
   end

   // Valid bits and status travel alongside the data stages.
   logic [LAT-1:0] vld_ff;
   status_type     st_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st_in;
      for (int i = 1; i < LAT; i++) begin
         st_ff[i] <= st_ff[i-1];
      end
   end

   // Median of each axis.
   logic [SAMPLE_BITS-1:0] med_x, med_y;

   tmam_median5 #(.W(SAMPLE_BITS)) u_med_x (
      .clock (clock),
      .samp  ({req_xs4, req_xs3, req_xs2, req_xs1, req_xs0}),
      .med   (med_x)
   );

   tmam_median5 #(.W(SAMPLE_BITS)) u_med_y (
      .clock (clock),
      .samp  ({req_ys4, req_ys3, req_ys2, req_ys1, req_ys0}),
      .med   (med_y)
   );

   // Medians wait for the affine stages.
   logic [SAMPLE_BITS-1:0] mx_dly_ff [LAT-MED_LAT];
   logic [SAMPLE_BITS-1:0] my_dly_ff [LAT-MED_LAT];

   always_ff @(posedge clock) begin
      mx_dly_ff[0] <= med_x;
      my_dly_ff[0] <= med_y;
      for (int i = 1; i < LAT - MED_LAT; i++) begin
         mx_dly_ff[i] <= mx_dly_ff[i-1];
         my_dly_ff[i] <= my_dly_ff[i-1];
      end
   end

   // Affine map of each screen axis.
   logic [SX_W-1:0] scr_x;
   logic [SY_W-1:0] scr_y;

   tmam_affine_axis #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (COEF_FRAC_BITS),
      .SIZE        (SCREEN_WIDTH),
      .OUT_W       (SX_W)
   ) u_map_x (
      .clock (clock),
      .coef  (coef_x_ff),
      .rx    (med_x),
      .ry    (med_y),
      .pos   (scr_x)
   );

   tmam_affine_axis #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (COEF_FRAC_BITS),
      .SIZE        (SCREEN_HEIGHT),
      .OUT_W       (SY_W)
   ) u_map_y (
      .clock (clock),
      .coef  (coef_y_ff),
      .rx    (med_x),
      .ry    (med_y),
      .pos   (scr_y)
   );

   // Response: fields read zero unless the status is ok.
   logic ok;

   assign ok           = (st_ff[LAT-1] == STATUS_OK);
   assign rsp_valid    = vld_ff[LAT-1];
   assign rsp_status   = st_ff[LAT-1];
   assign rsp_median_x = ok ? mx_dly_ff[LAT-MED_LAT-1] : '0;
   assign rsp_median_y = ok ? my_dly_ff[LAT-MED_LAT-1] : '0;
   assign rsp_col      = ok ? scr_x : '0;
   assign rsp_row      = ok ? scr_y : '0;

   // Every accepted transaction yields exactly one response.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("accepted transaction produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##6 !rsp_valid)
      else $error("response without an accepted transaction");

   // An ok response came from a calibrated, pressed request and stays on screen.
   a_ok_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |->
         ($past(cal_valid_ff, 6) && $past(req_pen_down, 6)))
      else $error("ok status without calibration or pen down");

   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |->
         (32'(rsp_col) < SCREEN_WIDTH && 32'(rsp_row) < SCREEN_HEIGHT))
      else $error("screen position outside the panel");

endmodule
